@@ src/tplc_pkg.sv @@
// Shared types and constants for the two-point linear calibration block.
// No dependencies.
`timescale 1ns / 1ps
package tplc_pkg;
    localparam logic [1:0] ST_SAMPLE    = 2'd0;
    localparam logic [1:0] ST_TWO_POINT = 2'd1;
    localparam logic [1:0] ST_OFFSET    = 2'd2;
    localparam logic [1:0] ST_SAME_RAW  = 2'd3;
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_CAPTURE = 1'b1;

    // serial multiplier and divider control
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } tplc_ctl_t;

    function automatic logic signed [31:0] tplc_sat32(input logic signed [65:0] v);
        logic signed [65:0] mx;
        logic signed [65:0] mn;
        mx = 66'sd2147483647;
        mn = -66'sd2147483648;
        if (v > mx) tplc_sat32 = 32'sh7FFFFFFF;
        else if (v < mn) tplc_sat32 = 32'sh80000000;
        else tplc_sat32 = v[31:0];
    endfunction
endpackage

@@ src/tplc_mul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
// Uses tplc_pkg.
`timescale 1ns / 1ps
module tplc_mul import tplc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p,
    output tplc_ctl_t          ctl
);
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] mcand_reg, mcand_next;
    logic [31:0]        mplier_reg, mplier_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    always_comb begin
        acc_next = acc_reg;
        mcand_next = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = '0;
            mcand_next = 64'(a);
            mplier_next = b;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // bit 31 of the multiplier carries negative weight
            if (mplier_reg[0]) begin
                if (cnt_reg == 6'd31) acc_next = acc_reg - mcand_reg;
                else acc_next = acc_reg + mcand_reg;
            end
            mcand_next = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        mcand_reg <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign p = acc_reg;
    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
endmodule

@@ src/tplc_div.sv @@
// Bit-serial restoring divider, truncating toward zero, one quotient bit per cycle.
// Uses tplc_pkg.
`timescale 1ns / 1ps
module tplc_div import tplc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [47:0] num,
    input  logic signed [24:0] den,
    output logic signed [47:0] quo,
    output tplc_ctl_t          ctl
);
    logic [47:0] q_reg, q_next;
    logic [25:0] r_reg, r_next;
    logic [24:0] d_reg, d_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [25:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[24:0], q_reg[47]};
        if (start) begin
            q_next = num[47] ? 48'(-num) : num;
            d_next = den[24] ? 25'(-den) : den;
            neg_next = num[47] ^ den[24];
            r_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[46:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
    end

    assign quo = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign ctl.start = start;
    assign ctl.busy = busy_reg;
    assign ctl.done = done_reg;
endmodule

@@ src/two_point_linear_calibration.sv @@
// Top level of the two-point linear calibration block; sequencer and state.
// Uses tplc_pkg, tplc_mul, tplc_div.
`timescale 1ns / 1ps
// One word at a time. A sample word runs the serial multiplier three
// times: the voltage channel, the current channel, then power. A capture word
// runs one multiply for the single-point offset. When both points exist and
// their raws differ, a serial divide and a further multiply follow.
// s_tready is high only while the sequencer is idle and the output register
// is free. The result waits in m_tdata until it is taken, and the next word
// can be accepted in the cycle after that. Calibrated values are
// floor(raw*scale/2^F)+offset, saturated to 32 bits. The scale is rise over run,
// truncated toward zero.
module two_point_linear_calibration import tplc_pkg::*; #(
    parameter int SCALE_FRAC_BITS = 16,
    parameter int RAW_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // from bit 0: raw_voltage, raw_current, channel, point_end, captured_raw,
    // reference_value (bits 0..73), zero fill to 80
    input  logic [79:0]  s_tdata,
    // req_type
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // from bit 0: calibrated_voltage, calibrated_current, power, new_scale,
    // new_offset
    output logic [191:0] m_tdata,
    // status
    output logic [1:0]   m_tuser
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MULV  = 7'b0000010,
        S_MULI  = 7'b0000100,
        S_MULP  = 7'b0001000,
        S_OFS   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OFS2  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic signed [31:0] gain_reg [2];
    logic signed [31:0] bias_reg [2];
    logic [RAW_BITS-1:0] lraw_reg [2];
    logic [RAW_BITS-1:0] hraw_reg [2];
    logic signed [23:0] ltrue_reg [2];
    logic signed [23:0] htrue_reg [2];
    logic [1:0] lseen_reg, hseen_reg;

    logic [15:0] ri_reg;
    logic        ch_reg;
    logic signed [31:0] v_reg, i_reg;
    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic signed [31:0] o_v_reg, o_i_reg, o_s_reg, o_b_reg;
    logic signed [63:0] o_p_reg;

    logic        mul_start;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    tplc_ctl_t   mul_ctl;
    logic        div_start;
    logic signed [47:0] div_num, div_q;
    logic signed [24:0] div_den;
    tplc_ctl_t   div_ctl;

    logic accept;
    logic in_req;
    logic [RAW_BITS-1:0] in_raw;
    logic in_ch, in_hi;
    logic signed [23:0] in_true;
    logic signed [31:0] cal_res, ofs_res, ofs1_res;
    logic signed [65:0] floor_p;
    // truth of the point being captured, held from acceptance
    logic signed [23:0] s_true_cap;

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept = s_tvalid && s_tready;
    assign in_req = s_tuser[0];
    assign in_ch = s_tdata[32];
    assign in_hi = s_tdata[33];
    assign in_raw = RAW_BITS'(s_tdata[49:34]);
    assign in_true = s_tdata[73:50];

    // arithmetic shift is floor division by 2^F
    assign floor_p = 66'(mul_p >>> SCALE_FRAC_BITS);
    assign cal_res = tplc_sat32(floor_p + 66'(bias_reg[ch_reg]));
    assign ofs_res = tplc_sat32(66'(ltrue_reg[ch_reg]) - floor_p);
    // single-point offset: captured truth minus scaled raw
    assign ofs1_res = tplc_sat32(66'(s_true_cap) - floor_p);

    tplc_mul u_mul (.aclk, .aresetn, .start(mul_start), .a(mul_a), .b(mul_b),
                    .p(mul_p), .ctl(mul_ctl));
    tplc_div u_div (.aclk, .aresetn, .start(div_start), .num(div_num),
                    .den(div_den), .quo(div_q), .ctl(div_ctl));

    logic [RAW_BITS-1:0] cur_raw;
    logic signed [31:0] dy;
    always_comb begin
        cur_raw = lraw_reg[ch_reg];
        dy = 32'(htrue_reg[ch_reg]) - 32'(ltrue_reg[ch_reg]);
        div_num = 48'(dy) <<< SCALE_FRAC_BITS;
        div_den = 25'(hraw_reg[ch_reg]) - 25'(lraw_reg[ch_reg]);
    end

    always_comb begin
        state_next = state_reg;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_IDLE: if (accept) begin
                mul_start = 1'b1;
                if (in_req == REQ_SAMPLE) begin
                    mul_a = 32'(RAW_BITS'(s_tdata[15:0]));
                    mul_b = gain_reg[0];
                    state_next = S_MULV;
                end else begin
                    mul_a = 32'(in_raw);
                    mul_b = gain_reg[in_ch];
                    state_next = S_OFS;
                end
            end
            S_MULV: if (mul_ctl.done) begin
                mul_start = 1'b1;
                mul_a = 32'(RAW_BITS'(ri_reg));
                mul_b = gain_reg[1];
                state_next = S_MULI;
            end
            S_MULI: if (mul_ctl.done) begin
                mul_start = 1'b1;
                mul_a = v_reg;
                mul_b = cal_res;
                state_next = S_MULP;
            end
            S_MULP: if (mul_ctl.done) state_next = S_IDLE;
            S_OFS: if (mul_ctl.done) begin
                if ((lseen_reg[ch_reg] && hseen_reg[ch_reg]) &&
                    (hraw_reg[ch_reg] != lraw_reg[ch_reg])) begin
                    div_start = 1'b1;
                    state_next = S_DIV;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_DIV: if (div_ctl.done) begin
                mul_start = 1'b1;
                mul_a = 32'(cur_raw);
                mul_b = tplc_sat32(66'(div_q));
                state_next = S_OFS2;
            end
            S_OFS2: if (mul_ctl.done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            lseen_reg <= '0;
            hseen_reg <= '0;
            for (int c = 0; c < 2; c++) begin
                gain_reg[c] <= 32'sd1 <<< SCALE_FRAC_BITS;
                bias_reg[c] <= '0;
                lraw_reg[c] <= '0;
                hraw_reg[c] <= '0;
                ltrue_reg[c] <= '0;
                htrue_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (accept) begin
                    ri_reg <= s_tdata[31:16];
                    if (in_req == REQ_CAPTURE) begin
                        ch_reg <= in_ch;
                        if (in_hi) begin
                            hraw_reg[in_ch] <= in_raw;
                            htrue_reg[in_ch] <= in_true;
                            hseen_reg[in_ch] <= 1'b1;
                        end else begin
                            lraw_reg[in_ch] <= in_raw;
                            ltrue_reg[in_ch] <= in_true;
                            lseen_reg[in_ch] <= 1'b1;
                        end
                    end else begin
                        ch_reg <= 1'b0;
                    end
                end
                S_MULV: if (mul_ctl.done) begin
                    v_reg <= cal_res;
                    ch_reg <= 1'b1;
                end
                S_MULI: if (mul_ctl.done) i_reg <= cal_res;
                S_MULP: if (mul_ctl.done) begin
                    out_valid_reg <= 1'b1;
                    out_status_reg <= ST_SAMPLE;
                    o_v_reg <= v_reg;
                    o_i_reg <= i_reg;
                    o_p_reg <= mul_p;
                    o_s_reg <= '0;
                    o_b_reg <= '0;
                end
                S_OFS: if (mul_ctl.done) begin
                    bias_reg[ch_reg] <= ofs1_res;
                    if (!((lseen_reg[ch_reg] && hseen_reg[ch_reg]) &&
                          (hraw_reg[ch_reg] != lraw_reg[ch_reg]))) begin
                        out_valid_reg <= 1'b1;
                        out_status_reg <= (lseen_reg[ch_reg] && hseen_reg[ch_reg]) ?
                                          ST_SAME_RAW : ST_OFFSET;
                        o_v_reg <= '0;
                        o_i_reg <= '0;
                        o_p_reg <= '0;
                        o_s_reg <= gain_reg[ch_reg];
                        o_b_reg <= ofs1_res;
                    end
                end
                S_DIV: if (div_ctl.done) gain_reg[ch_reg] <= tplc_sat32(66'(div_q));
                S_OFS2: if (mul_ctl.done) begin
                    bias_reg[ch_reg] <= ofs_res;
                    out_valid_reg <= 1'b1;
                    out_status_reg <= ST_TWO_POINT;
                    o_v_reg <= '0;
                    o_i_reg <= '0;
                    o_p_reg <= '0;
                    o_s_reg <= gain_reg[ch_reg];
                    o_b_reg <= ofs_res;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) s_true_cap <= in_true;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_status_reg;
    assign m_tdata = {o_b_reg, o_s_reg, o_p_reg, o_i_reg, o_v_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("accepted a word while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result lost while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mul_ctl.busy && div_ctl.busy))
        else $error("multiplier and divider both active");
endmodule
